// File: sv/utg_pkg.sv
// Shared types and the code point fold table for the UTF-8 glyph layout block.
// No dependencies; imported by utg_step and utf8_text_glyph_layout.
`default_nettype none

package utg_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned COL_W    = 8;
    localparam int unsigned GLYPH_W  = 7;

    localparam logic [GLYPH_W-1:0] GLYPH_UNKNOWN = 7'h3F;   // '?'
    localparam logic [CP_W-1:0]    CP_PRINT_LO   = 21'd32;
    localparam logic [CP_W-1:0]    CP_PRINT_HI   = 21'd126;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COL_W-1:0]   wrap_columns;
    } utg_cfg_t;

    typedef struct packed {
        logic [CP_W-1:0]    partial;
        logic [1:0]         cont_left;
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic [COL_W-1:0]   col_count;
    } utg_state_t;

    typedef struct packed {
        logic               draw_glyph;
        logic [GLYPH_W-1:0] glyph_code;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               string_done;
    } utg_result_t;

    // Fold a code point to a printable ASCII glyph.
    function automatic logic [GLYPH_W-1:0] fold_glyph(input logic [CP_W-1:0] cp);
        logic [GLYPH_W-1:0] g;
        g = GLYPH_UNKNOWN;
        if (cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) begin
            g = cp[GLYPH_W-1:0];
        end else if (cp[CP_W-1:16] == '0) begin
            unique case (cp[15:0])
                16'h00A1: g = 7'h21;    // !
                16'h00A9: g = 7'h43;    // C
                16'h00AE: g = 7'h52;    // R
                16'h00B2: g = 7'h32;
                16'h00B3: g = 7'h33;
                16'h00B9: g = 7'h31;
                16'h00BC, 16'h00BD, 16'h00BE, 16'h00F7: g = 7'h2F;  // /
                16'h00BF: g = 7'h3F;
                16'h00C0, 16'h00C1, 16'h00C2, 16'h00C3, 16'h00C4, 16'h00C5: g = 7'h41;
                16'h00C7: g = 7'h43;
                16'h00C8, 16'h00C9, 16'h00CA, 16'h00CB: g = 7'h45;
                16'h00CC, 16'h00CD, 16'h00CE, 16'h00CF: g = 7'h49;
                16'h00D0: g = 7'h44;
                16'h00D1: g = 7'h4E;
                16'h00D2, 16'h00D3, 16'h00D4, 16'h00D5, 16'h00D6, 16'h00D8: g = 7'h4F;
                16'h00D7: g = 7'h78;    // x
                16'h00D9, 16'h00DA, 16'h00DB, 16'h00DC: g = 7'h55;
                16'h00DD: g = 7'h59;
                16'h00DE: g = 7'h54;
                16'h00E0, 16'h00E1, 16'h00E2, 16'h00E3, 16'h00E4, 16'h00E5: g = 7'h61;
                16'h00E7: g = 7'h63;
                16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB: g = 7'h65;
                16'h00EC, 16'h00ED, 16'h00EE, 16'h00EF: g = 7'h69;
                16'h00F0: g = 7'h64;
                16'h00F1: g = 7'h6E;
                16'h00F2, 16'h00F3, 16'h00F4, 16'h00F5, 16'h00F6, 16'h00F8: g = 7'h6F;
                16'h00F9, 16'h00FA, 16'h00FB, 16'h00FC: g = 7'h75;
                16'h00FD, 16'h00FF: g = 7'h79;
                16'h00FE: g = 7'h74;
                16'h2013, 16'h2014: g = 7'h2D;  // dashes
                16'h2018, 16'h2019: g = 7'h27;  // single quotes
                16'h201C, 16'h201D: g = 7'h22;  // double quotes
                16'h2026: g = 7'h2E;            // ellipsis
                16'h2122: g = 7'h54;            // trade mark
                default:  g = GLYPH_UNKNOWN;
            endcase
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// File: sv/utg_step.sv
// One byte of UTF-8 decode, glyph fold and cursor placement, purely combinational.
// Depends on utg_pkg for the state, config and result types and the fold table.
`default_nettype none

module utg_step
    import utg_pkg::*;
#(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 16,
    parameter int LINE_GAP     = 2
) (
    input  wire utg_cfg_t   cfg,
    input  wire utg_state_t cur,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output utg_state_t      nxt,
    output utg_result_t     res
);

    localparam logic [COORD_W-1:0] X_STEP = COORD_W'(GLYPH_WIDTH);
    localparam logic [COORD_W-1:0] Y_STEP = COORD_W'(GLYPH_HEIGHT + LINE_GAP);
    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [COL_W-1:0] COL_MAX = '1;

    logic               done;
    logic [CP_W-1:0]    cp;
    logic               do_place;
    logic [GLYPH_W-1:0] glyph;
    utg_state_t         dec;
    logic [CP_W-1:0]    shifted;

    assign shifted = {cur.partial[CP_W-7:0], text_byte[5:0]};

    // decode stage: sequence tracking and newline
    always_comb
    begin
        dec  = cur;
        done = 1'b0;
        cp   = '0;
        if (cur.cont_left != 2'd0) begin
            if (text_byte[7:6] == 2'b10) begin
                dec.partial   = shifted;
                dec.cont_left = cur.cont_left - 2'd1;
                if (cur.cont_left == 2'd1) begin
                    done = 1'b1;
                    cp   = shifted;
                end
            end else begin
                // bad continuation byte is consumed
                dec.cont_left = 2'd0;
                done          = 1'b1;
            end
        end else if (text_byte == BYTE_NEWLINE) begin
            dec.cursor_y  = cur.cursor_y + Y_STEP;
            dec.cursor_x  = cfg.origin_x;
            dec.col_count = '0;
        end else if (!text_byte[7]) begin
            done = 1'b1;
            cp   = CP_W'(text_byte);
        end else if (text_byte[7:5] == 3'b110) begin
            dec.partial   = CP_W'(text_byte[4:0]);
            dec.cont_left = 2'd1;
        end else if (text_byte[7:4] == 4'b1110) begin
            dec.partial   = CP_W'(text_byte[3:0]);
            dec.cont_left = 2'd2;
        end else if (text_byte[7:3] == 5'b11110) begin
            dec.partial   = CP_W'(text_byte[2:0]);
            dec.cont_left = 2'd3;
        end else begin
            done = 1'b1;
        end
    end

    assign do_place = done || (end_of_text && dec.cont_left != 2'd0);
    assign glyph    = done ? fold_glyph(cp) : GLYPH_UNKNOWN;

    // placement with optional wrap, then end-of-string restore
    always_comb
    begin
        nxt             = dec;
        res             = '0;
        res.string_done = end_of_text;
        if (done) begin
            nxt.partial = '0;
        end
        if (do_place) begin
            if (cfg.wrap_columns != '0 && dec.col_count >= cfg.wrap_columns) begin
                nxt.cursor_y  = dec.cursor_y + Y_STEP;
                nxt.cursor_x  = cfg.origin_x;
                nxt.col_count = '0;
            end
            res.draw_glyph = 1'b1;
            res.glyph_code = glyph;
            res.pos_x      = nxt.cursor_x;
            res.pos_y      = nxt.cursor_y;
            nxt.cursor_x   = nxt.cursor_x + X_STEP;
            if (nxt.col_count != COL_MAX) begin
                nxt.col_count = nxt.col_count + COL_W'(1);
            end
        end
        if (end_of_text) begin
            nxt.partial   = '0;
            nxt.cont_left = 2'd0;
            nxt.cursor_x  = cfg.origin_x;
            nxt.cursor_y  = cfg.origin_y;
            nxt.col_count = '0;
        end
    end

endmodule

`default_nettype wire

// File: sv/utf8_text_glyph_layout.sv
// Top level of the UTF-8 glyph layout block: config registers, decode state, output queue.
// Depends on utg_pkg and utg_step.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  text in  | text_valid / text_stall   | text_byte, end_of_text
//  glyph out| glyph_valid / glyph_stall | draw_glyph, glyph_code, pos_x, pos_y, string_done
//  config   | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// One byte per cycle while text_stall is low; decode, fold and placement finish in the accept
// cycle and the result is registered into a two-entry output queue.
// text_stall is a register: it rises only when both queue entries hold results.
// Reset clears decode state and the queue, origins and wrap count go to zero.
`default_nettype none

module utf8_text_glyph_layout
    import utg_pkg::*;
#(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 16,
    parameter int LINE_GAP     = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               text_valid,
    output logic                    text_stall,
    input  wire logic [7:0]         text_byte,
    input  wire logic               end_of_text,
    output logic                    glyph_valid,
    input  wire logic               glyph_stall,
    output logic                    draw_glyph,
    output logic      [6:0]         glyph_code,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic                    string_done
);

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_WRAP     = 2'd2;

    utg_cfg_t    cfg_reg;
    utg_state_t  state_reg;
    utg_state_t  state_next;
    utg_result_t step_res;

    utg_result_t q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        full_reg;

    logic        cfg_wr;
    logic        push;
    logic        pop;
    utg_result_t head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ORIGIN_X: prdata = 32'(cfg_reg.origin_x);
            REG_ORIGIN_Y: prdata = 32'(cfg_reg.origin_y);
            REG_WRAP:     prdata = 32'(cfg_reg.wrap_columns);
            default:      prdata = '0;
        endcase
    end

    utg_step #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .LINE_GAP     (LINE_GAP)
    ) u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .nxt         (state_next),
        .res         (step_res)
    );

    assign text_stall  = full_reg;
    assign glyph_valid = count_reg != 2'd0;
    assign push        = text_valid && !full_reg;
    assign pop         = glyph_valid && !glyph_stall;
    assign count_next  = count_reg + 2'(push) - 2'(pop);

    // config and decode state; origin writes also reload the cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg   <= '0;
            state_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ORIGIN_X:
                begin
                    cfg_reg.origin_x   <= pwdata[15:0];
                    state_reg.cursor_x <= pwdata[15:0];
                end
                REG_ORIGIN_Y:
                begin
                    cfg_reg.origin_y   <= pwdata[15:0];
                    state_reg.cursor_y <= pwdata[15:0];
                end
                REG_WRAP:
                begin
                    cfg_reg.wrap_columns <= pwdata[7:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end else if (push) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            full_reg   <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
            full_reg  <= count_next == 2'd2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_reg[wr_ptr_reg] <= step_res;
        end
    end

    assign head        = q_reg[rd_ptr_reg];
    assign draw_glyph  = head.draw_glyph;
    assign glyph_code  = head.glyph_code;
    assign pos_x       = head.pos_x;
    assign pos_y       = head.pos_y;
    assign string_done = head.string_done;

endmodule

`default_nettype wire

// File: verif/utf8_text_glyph_layout_tb.sv
// Self-checking testbench for utf8_text_glyph_layout: UTF-8 bytes in, placed glyphs out.
// Needs only the RTL (utg_pkg, utg_step, utf8_text_glyph_layout); expected glyphs are
// predicted locally from the accepted bytes and the APB register settings.
`timescale 1ns / 100ps

module utf8_text_glyph_layout_tb;

    localparam int GLYPH_W_PX  = 8;
    localparam int GLYPH_H_PX  = 16;
    localparam int LINE_GAP_PX = 2;

    localparam logic [3:0] ADDR_ORIGIN_X = 4'h0;
    localparam logic [3:0] ADDR_ORIGIN_Y = 4'h4;
    localparam logic [3:0] ADDR_WRAP     = 4'h8;
    localparam logic [3:0] ADDR_UNMAPPED = 4'hC;

    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [6:0] GLYPH_QMARK  = 7'h3F;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         MAX_PRINTED  = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } text_unit_t;

    typedef struct packed {
        logic        draw;
        logic [6:0]  glyph;
        logic [15:0] x;
        logic [15:0] y;
        logic        done;
    } glyph_rec_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        text_valid = 1'b0;
    logic        text_stall;
    logic [7:0]  text_byte = '0;
    logic        end_of_text = 1'b0;
    logic        glyph_valid;
    logic        glyph_stall = 1'b0;
    logic        draw_glyph;
    logic [6:0]  glyph_code;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        string_done;

    // layout model: registers and decode/cursor state
    logic [15:0] org_x = '0;
    logic [15:0] org_y = '0;
    logic [7:0]  wrap_cols = '0;
    logic [20:0] part_cp = '0;
    logic [1:0]  cont_left = '0;
    logic [15:0] cur_x = '0;
    logic [15:0] cur_y = '0;
    logic [7:0]  col_cnt = '0;

    text_unit_t  text_to_send[$];
    glyph_rec_t  pending_glyphs[$];

    int          errors = 0;
    int          accepted_bytes = 0;
    int          glyphs_checked = 0;
    int          strings_queued = 0;
    int          line_breaks = 0;
    int          layout_settings = 0;
    int          long_holds = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          window_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    utf8_text_glyph_layout dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .draw_glyph  (draw_glyph),
        .glyph_code  (glyph_code),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .string_done (string_done)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_PRINTED)
        begin
            $display("ERROR @%0t glyph #%0d %s: got 0x%0h, want 0x%0h",
                     $time, glyphs_checked, what, got, want);
        end
        errors++;
    endtask

    function automatic logic [6:0] ascii_fold(input logic [20:0] cp);
        string       latin;
        logic [6:0]  g;
        // U+00C0..U+00FF, one glyph per code point
        latin = "AAAAAA?CEEEEIIIIDNOOOOOxOUUUUYT?aaaaaa?ceeeeiiiidnooooo/ouuuuyty";
        g = GLYPH_QMARK;
        if (cp >= 21'd32 && cp <= 21'd126)
        begin
            g = cp[6:0];
        end
        else if (cp >= 21'h0000C0 && cp <= 21'h0000FF)
        begin
            g = 7'(latin[int'(cp[5:0])]);
        end
        else
        begin
            case (cp)
                21'h0000A1: g = 7'h21;
                21'h0000A9: g = 7'h43;
                21'h0000AE: g = 7'h52;
                21'h0000B2: g = 7'h32;
                21'h0000B3: g = 7'h33;
                21'h0000B9: g = 7'h31;
                21'h0000BC, 21'h0000BD, 21'h0000BE: g = 7'h2F;
                21'h002013, 21'h002014: g = 7'h2D;
                21'h002018, 21'h002019: g = 7'h27;
                21'h00201C, 21'h00201D: g = 7'h22;
                21'h002026: g = 7'h2E;
                21'h002122: g = 7'h54;
                default: g = GLYPH_QMARK;
            endcase
        end
        return g;
    endfunction

    function automatic void new_line();
        cur_y = cur_y + 16'(GLYPH_H_PX + LINE_GAP_PX);
        cur_x = org_x;
        col_cnt = '0;
        line_breaks++;
    endfunction

    function automatic void place_glyph(input logic [6:0] g, inout glyph_rec_t r);
        if (wrap_cols != 0 && col_cnt >= wrap_cols)
        begin
            new_line();
        end
        r.draw  = 1'b1;
        r.glyph = g;
        r.x     = cur_x;
        r.y     = cur_y;
        cur_x   = cur_x + 16'(GLYPH_W_PX);
        if (col_cnt != 8'hFF)
        begin
            col_cnt++;
        end
    endfunction

    function automatic glyph_rec_t layout_next_glyph(input logic [7:0] b, input logic eot);
        glyph_rec_t  r;
        logic        complete;
        logic [20:0] cp;
        r = '0;
        r.done = eot;
        complete = 1'b0;
        cp = '0;
        if (cont_left != 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                part_cp = {part_cp[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0)
                begin
                    complete = 1'b1;
                    cp = part_cp;
                end
            end
            else
            begin
                // broken sequence swallows the offending byte
                cont_left = '0;
                complete = 1'b1;
            end
        end
        else if (b == BYTE_NEWLINE)
        begin
            new_line();
        end
        else if (!b[7])
        begin
            complete = 1'b1;
            cp = {13'd0, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            part_cp = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            part_cp = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            part_cp = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end
        else
        begin
            complete = 1'b1;
        end

        if (complete)
        begin
            part_cp = '0;
            place_glyph(ascii_fold(cp), r);
        end
        else if (eot && cont_left != 0)
        begin
            place_glyph(GLYPH_QMARK, r);
        end

        if (eot)
        begin
            part_cp = '0;
            cont_left = '0;
            cur_x = org_x;
            cur_y = org_y;
            col_cnt = '0;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_ORIGIN_X:
            begin
                org_x = value[15:0];
                cur_x = value[15:0];
            end
            ADDR_ORIGIN_Y:
            begin
                org_y = value[15:0];
                cur_y = value[15:0];
            end
            ADDR_WRAP: wrap_cols = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_layout(input logic [15:0] x, input logic [15:0] y, input logic [7:0] w);
        write_reg(ADDR_ORIGIN_X, {16'($urandom_range(0, 65535)), x});
        write_reg(ADDR_ORIGIN_Y, {16'h0, y});
        write_reg(ADDR_WRAP, {24'h0, w});
        layout_settings++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        text_to_send.push_back('{data: b, eot: 1'b0});
    endtask

    task automatic mark_end();
        text_unit_t tail;
        tail = text_to_send.pop_back();
        tail.eot = 1'b1;
        text_to_send.push_back(tail);
        strings_queued++;
    endtask

    // lax UTF-8 encoding of cp in nbytes bytes; only the first keep bytes are queued
    task automatic push_utf8(input logic [20:0] cp, input int nbytes, input int keep);
        int k;
        int sent;
        if (nbytes == 2)
            push_byte({3'b110, cp[10:6]});
        else if (nbytes == 3)
            push_byte({4'b1110, cp[15:12]});
        else
            push_byte({5'b11110, cp[20:18]});
        sent = 1;
        for (k = nbytes - 2; k >= 0 && sent < keep; k--)
        begin
            push_byte({2'b10, cp[6*k +: 6]});
            sent++;
        end
    endtask

    task automatic queue_string(input int len);
        int          start;
        int          kind;
        int          nb;
        logic [7:0]  b;
        logic [20:0] cp;
        start = text_to_send.size();
        while (text_to_send.size() - start < len)
        begin
            kind = $urandom_range(0, 99);
            cp = 21'($urandom);
            if (kind < 40)
                push_byte(8'($urandom_range(32, 126)));
            else if (kind < 46)
                push_byte(BYTE_NEWLINE);
            else if (kind < 50)
                push_byte(8'($urandom_range(0, 31)));
            else if (kind < 62)
            begin
                if ($urandom_range(0, 1) == 1)
                    cp = 21'($urandom_range('hA0, 'hFF));
                push_utf8(cp, 2, 2);
            end
            else if (kind < 70)
            begin
                case ($urandom_range(0, 9))
                    0: cp = 21'h2013;
                    1: cp = 21'h2014;
                    2: cp = 21'h2018;
                    3: cp = 21'h2019;
                    4: cp = 21'h201C;
                    5: cp = 21'h201D;
                    6: cp = 21'h2026;
                    7: cp = 21'h2122;
                    default: ;
                endcase
                push_utf8(cp, 3, 3);
            end
            else if (kind < 76)
                push_utf8(cp, 4, 4);
            else if (kind < 82)
                push_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                               : 8'($urandom_range('hF8, 'hFF)));
            else if (kind < 92)
            begin
                // truncated sequence cut off by any non-continuation byte
                nb = $urandom_range(2, 4);
                push_utf8(cp, nb, $urandom_range(1, nb - 1));
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                push_byte($urandom_range(0, 3) == 0 ? BYTE_NEWLINE : b);
            end
            else
                push_byte(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            nb = $urandom_range(2, 4);
            push_utf8(21'($urandom), nb, $urandom_range(1, nb - 1));
        end
        mark_end();
    endtask

    // sampled mid-cycle so the driver's updates at the edge have settled
    task automatic wait_drained();
        while (text_to_send.size() != 0 || text_valid || pending_glyphs.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin : drive_text
        text_unit_t unit;
        if (rst_n)
        begin
            if (text_valid && !text_stall)
            begin
                pending_glyphs.push_back(layout_next_glyph(text_byte, end_of_text));
                accepted_bytes <= accepted_bytes + 1;
            end
            if (text_valid && text_stall)
                ;
            else if (gap_left > 0)
            begin
                text_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (text_to_send.size() != 0)
            begin
                unit = text_to_send.pop_front();
                text_valid  <= 1'b1;
                text_byte   <= unit.data;
                end_of_text <= unit.eot;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                text_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with two long hold-offs to back up the block
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            glyph_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (long_holds < 2 && accepted_bytes >= 150 + 270 * long_holds)
        begin
            glyph_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            long_holds <= long_holds + 1;
        end
        else
        begin
            if (window_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                window_left <= $urandom_range(20, 120);
            end
            else
                window_left <= window_left - 1;
            case (stall_mode)
                STALL_NONE:   glyph_stall <= 1'b0;
                STALL_LIGHT:  glyph_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  glyph_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: glyph_stall <= !glyph_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_glyphs
        glyph_rec_t want;
        if (rst_n && glyph_valid && !glyph_stall)
        begin
            if (pending_glyphs.size() == 0)
                report_mismatch("unexpected transfer, glyph_code", 32'(glyph_code), 32'h0);
            else
            begin
                want = pending_glyphs.pop_front();
                if (draw_glyph !== want.draw)
                    report_mismatch("draw_glyph", 32'(draw_glyph), 32'(want.draw));
                if (glyph_code !== want.glyph)
                    report_mismatch("glyph_code", 32'(glyph_code), 32'(want.glyph));
                if (pos_x !== want.x)
                    report_mismatch("pos_x", 32'(pos_x), 32'(want.x));
                if (pos_y !== want.y)
                    report_mismatch("pos_y", 32'(pos_y), 32'(want.y));
                if (string_done !== want.done)
                    report_mismatch("string_done", 32'(string_done), 32'(want.done));
            end
            glyphs_checked++;
        end
    end

    initial
    begin
        #4_800_000;
        $display("Timed out with %0d glyphs outstanding", pending_glyphs.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every decode path, broken and unfinished sequences
        set_layout(16'd3, 16'd5, 8'd4);
        push_byte(8'h41);
        push_byte(8'h7E);
        push_byte(8'h20);
        push_byte(8'h00);
        push_byte(8'h1F);
        push_byte(BYTE_NEWLINE);
        push_utf8(21'h0000E9, 2, 2);
        push_utf8(21'h002014, 3, 3);
        push_utf8(21'h01F600, 4, 4);
        push_byte(8'h80);
        push_byte(8'hFF);
        push_byte(8'hF8);
        push_byte(8'hC3);
        push_byte(BYTE_NEWLINE);
        push_byte(8'hC3);
        push_byte(8'hE2);
        push_byte(8'hE2);
        push_byte(8'h82);
        mark_end();
        push_byte(8'h5A);
        mark_end();
        wait_drained();

        // unmapped register must be ignored
        write_reg(ADDR_UNMAPPED, $urandom);

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_layout(16'h8000, 16'h7FFF, 8'd1);
                1:
                begin
                    set_layout(16'h7FFF, 16'h8000, 8'd255);
                    // one line long enough to hit the 255-column wrap
                    repeat (260) push_byte(8'($urandom_range(32, 126)));
                    mark_end();
                end
                2: set_layout(16'h0000, 16'h0000, 8'd0);
                3: set_layout(16'hFFF0, 16'hFFE0, 8'd5);
                default: set_layout(16'($urandom), 16'($urandom), 8'($urandom_range(1, 12)));
            endcase
            while (text_to_send.size() < 30)
                queue_string($urandom_range(1, 20));
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d bytes in %0d strings, checked %0d glyph transfers",
                 accepted_bytes, strings_queued, glyphs_checked);
        $display("%0d layout settings, %0d line breaks, %0d long receiver hold-offs",
                 layout_settings, line_breaks, long_holds);
        if (errors == 0 && pending_glyphs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/utg_pkg.sv
sv/utg_step.sv
sv/utf8_text_glyph_layout.sv
verif/utf8_text_glyph_layout_tb.sv
